[hdl/assert_macros.svh]
// Assertion macros used by the top-level RTL file to check its own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");
`define ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, expr)
`define ASSERT_IMPLY(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[hdl/tcw_pkg.sv]
// Types, constants, microcode table and helper functions of the console cell writer.
package tcw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = ROWS * COLUMNS;

  localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int COL_W   = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int ADDR_W  = 11;
  localparam int DATA_W  = 16;
  localparam int CHAR_W  = 8;
  localparam int NUM_W   = 32;
  localparam int OP_W    = 2;
  localparam int POS_W   = 16;
  localparam int PC_W    = 4;
  localparam int CNT_W   = 4;
  localparam int DIGIT_W = 4;
  localparam int DEC_DIGITS = 10;
  localparam int HEX_DIGITS = NUM_W / DIGIT_W;
  localparam int STACK_W = DEC_DIGITS * DIGIT_W;

  localparam logic [CHAR_W-1:0] ATTR_RESET   = 8'h0F;
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_A       = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_X       = 8'h78;
  localparam int RADIX = 10;

  localparam logic [NUM_W-1:0] RECIP_TEN = 32'hCCCC_CCCD;
  localparam int RECIP_SHIFT = 35;

  typedef enum logic [OP_W-1:0] {
    OP_PUT  = 2'd0,
    OP_MOVE = 2'd1,
    OP_DEC  = 2'd2,
    OP_HEX  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    EM_NONE, EM_CHAR, EM_MOVE, EM_MINUS, EM_DIGIT, EM_HEX, EM_ZERO, EM_X
  } emit_t;

  typedef enum logic [1:0] {WK_NONE, WK_DIV, WK_SHIFT} work_t;
  typedef enum logic [1:0] {CN_HOLD, CN_INC, CN_DEC} cnt_op_t;
  typedef enum logic [1:0] {LS_NEVER, LS_ALWAYS, LS_CNT_ONE, LS_CNT_LAST_HEX} last_t;
  typedef enum logic [1:0] {JP_NONE, JP_ALWAYS, JP_QNZ, JP_DISPATCH} jump_t;

  localparam logic [PC_W-1:0] ST_IDLE  = 4'd0;
  localparam logic [PC_W-1:0] ST_PUT   = 4'd1;
  localparam logic [PC_W-1:0] ST_MOVE  = 4'd2;
  localparam logic [PC_W-1:0] ST_SIGN  = 4'd3;
  localparam logic [PC_W-1:0] ST_DIV   = 4'd4;
  localparam logic [PC_W-1:0] ST_DOUT  = 4'd5;
  localparam logic [PC_W-1:0] ST_HZERO = 4'd6;
  localparam logic [PC_W-1:0] ST_HX    = 4'd7;
  localparam logic [PC_W-1:0] ST_HDIG  = 4'd8;

  typedef struct packed {
    emit_t             emit;
    work_t             work;
    cnt_op_t           cnt_op;
    last_t             last;
    jump_t             jump;
    logic [PC_W-1:0]   target;
  } ucode_t;

  typedef struct packed {
    ucode_t cw;
    logic   fire;
    logic   load;
    logic   emit;
    logic   last;
  } ctrl_t;

  typedef struct packed {
    logic neg;
    logic q_nonzero;
    logic cnt_one;
    logic cnt_last_hex;
    logic out_free;
  } status_t;

  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    w = '{emit: EM_NONE, work: WK_NONE, cnt_op: CN_HOLD, last: LS_NEVER,
          jump: JP_DISPATCH, target: ST_IDLE};
    case (pc)
      ST_IDLE:  w = '{EM_NONE,  WK_NONE,  CN_HOLD, LS_NEVER,        JP_DISPATCH, ST_IDLE};
      ST_PUT:   w = '{EM_CHAR,  WK_NONE,  CN_HOLD, LS_ALWAYS,       JP_NONE,     ST_IDLE};
      ST_MOVE:  w = '{EM_MOVE,  WK_NONE,  CN_HOLD, LS_ALWAYS,       JP_NONE,     ST_IDLE};
      ST_SIGN:  w = '{EM_MINUS, WK_NONE,  CN_HOLD, LS_NEVER,        JP_NONE,     ST_IDLE};
      ST_DIV:   w = '{EM_NONE,  WK_DIV,   CN_INC,  LS_NEVER,        JP_QNZ,      ST_DIV};
      ST_DOUT:  w = '{EM_DIGIT, WK_NONE,  CN_DEC,  LS_CNT_ONE,      JP_ALWAYS,   ST_DOUT};
      ST_HZERO: w = '{EM_ZERO,  WK_NONE,  CN_HOLD, LS_NEVER,        JP_NONE,     ST_IDLE};
      ST_HX:    w = '{EM_X,     WK_NONE,  CN_HOLD, LS_NEVER,        JP_NONE,     ST_IDLE};
      ST_HDIG:  w = '{EM_HEX,   WK_SHIFT, CN_INC,  LS_CNT_LAST_HEX, JP_ALWAYS,   ST_HDIG};
      default:  w = '{EM_NONE,  WK_NONE,  CN_HOLD, LS_NEVER,        JP_DISPATCH, ST_IDLE};
    endcase
    return w;
  endfunction

  function automatic logic [PC_W-1:0] dispatch_step(input op_t op);
    logic [PC_W-1:0] s;
    case (op)
      OP_PUT:  s = ST_PUT;
      OP_MOVE: s = ST_MOVE;
      OP_DEC:  s = ST_SIGN;
      OP_HEX:  s = ST_HZERO;
      default: s = ST_IDLE;
    endcase
    return s;
  endfunction

  function automatic logic [ADDR_W-1:0] cell_pos(input logic [ROW_W-1:0] r,
                                                 input logic [COL_W-1:0] c);
    logic [POS_W-1:0] p;
    p = POS_W'(r) * POS_W'(COLUMNS) + POS_W'(c);
    return p[ADDR_W-1:0];
  endfunction

  function automatic logic [CHAR_W-1:0] nibble_ascii(input logic [DIGIT_W-1:0] nib);
    logic [CHAR_W-1:0] ch;
    if (nib < DIGIT_W'(RADIX)) begin
      ch = CHAR_ZERO + CHAR_W'(nib);
    end else begin
      ch = CHAR_A + CHAR_W'(nib) - CHAR_W'(RADIX);
    end
    return ch;
  endfunction

endpackage

[hdl/tcw_if.sv]
// Channel interfaces of the console cell writer: items, results and attribute writes.
interface tcw_in_if;
  import tcw_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          operation;
  logic [CHAR_W-1:0]        char_code;
  logic [CHAR_W-1:0]        row;
  logic [CHAR_W-1:0]        column;
  logic signed [NUM_W-1:0]  number;
  modport source (output valid, operation, char_code, row, column, number, input ready);
  modport sink (input valid, operation, char_code, row, column, number, output ready);
endinterface

interface tcw_out_if;
  import tcw_pkg::*;
  logic                valid;
  logic                ready;
  logic                write_enable;
  logic [ADDR_W-1:0]   cell_address;
  logic [DATA_W-1:0]   cell_data;
  logic [ADDR_W-1:0]   cursor_position;
  logic                last;
  modport source (output valid, write_enable, cell_address, cell_data, cursor_position,
                  last, input ready);
  modport sink (input valid, write_enable, cell_address, cell_data, cursor_position,
                last, output ready);
endinterface

interface tcw_cfg_if;
  import tcw_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

[hdl/text_console_cell_writer.sv]
// Top level of the text console cell writer: sequencer, datapath and checks.
//
//   channel   dir   handshake      payload
//   request   in    valid/ready    operation, char_code, row, column, number
//   result    out   valid/ready    write_enable, cell_address, cell_data,
//                                  cursor_position, last
//   cfg       in    valid/ready    data (attribute byte), always ready
//
// Put character and move cursor take the accept and one microcode step.
// Decimal takes the accept, the sign step, one reciprocal multiply per digit in
// the divide step, then one transfer per digit.
// Hex takes the accept, the "0x" prefix and eight nibble steps.
// Reset returns the step counter to idle, homes the cursor and sets attribute 0x0F.
// A step that emits waits while the result register holds an untaken transfer.
`include "assert_macros.svh"

module text_console_cell_writer (
  input  logic       clk,
  input  logic       rst,
  tcw_in_if.sink     request,
  tcw_out_if.source  result,
  tcw_cfg_if.sink    cfg
);
  import tcw_pkg::*;

  ctrl_t   ctrl;
  status_t status;
  logic    seq_ready;
  logic    no_payload;

  tcw_sequencer u_sequencer (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (request.valid),
    .operation (request.operation),
    .status    (status),
    .ctrl      (ctrl),
    .in_ready  (seq_ready)
  );

  tcw_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .status  (status),
    .request (request),
    .result  (result),
    .cfg     (cfg)
  );

  assign request.ready = seq_ready;
  assign no_payload    = (result.cell_address == '0) && (result.cell_data == '0);

  `ASSERT_IMPLY(a_busy_mid_item, result.valid && !result.last, !request.ready)
  `ASSERT_NEXT(a_leave_idle, request.valid && request.ready, !request.ready)
  `ASSERT_IMPLY(a_nowrite_zero, result.valid && !result.write_enable, no_payload)
  `ASSERT_IMPLY(a_pos_range, result.valid, 16'(result.cursor_position) < 16'(CELLS))

endmodule

[hdl/tcw_sequencer.sv]
// Microcode sequencer: step counter, control word fetch and conditional jumps.
module tcw_sequencer (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic [tcw_pkg::OP_W-1:0]  operation,
  input  tcw_pkg::status_t          status,
  output tcw_pkg::ctrl_t            ctrl,
  output logic                      in_ready
);
  import tcw_pkg::*;

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  ucode_t          cw;
  logic            emit_needed;
  logic            fire;
  logic            last_now;

  always_comb begin
    cw = ucode_rom(pc);
    emit_needed = (cw.emit != EM_NONE) && !((cw.emit == EM_MINUS) && !status.neg);
    if (cw.jump == JP_DISPATCH) begin
      fire = in_valid;
    end else begin
      fire = !emit_needed || status.out_free;
    end
    case (cw.last)
      LS_NEVER:        last_now = 1'b0;
      LS_ALWAYS:       last_now = 1'b1;
      LS_CNT_ONE:      last_now = status.cnt_one;
      LS_CNT_LAST_HEX: last_now = status.cnt_last_hex;
      default:         last_now = 1'b0;
    endcase
    pc_next = pc;
    if (fire) begin
      if (last_now) begin
        pc_next = ST_IDLE;
      end else begin
        case (cw.jump)
          JP_NONE:     pc_next = pc + PC_W'(1);
          JP_ALWAYS:   pc_next = cw.target;
          JP_QNZ:      pc_next = status.q_nonzero ? cw.target : pc + PC_W'(1);
          JP_DISPATCH: pc_next = dispatch_step(op_t'(operation));
          default:     pc_next = ST_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= ST_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  assign in_ready  = (cw.jump == JP_DISPATCH);
  assign ctrl.cw   = cw;
  assign ctrl.fire = fire;
  assign ctrl.load = fire && (cw.jump == JP_DISPATCH);
  assign ctrl.emit = fire && emit_needed;
  assign ctrl.last = last_now;

endmodule

[hdl/tcw_datapath.sv]
// Datapath: cursor, attribute, digit conversion, digit stack and result register.
module tcw_datapath (
  input  logic              clk,
  input  logic              rst,
  input  tcw_pkg::ctrl_t    ctrl,
  output tcw_pkg::status_t  status,
  tcw_in_if.sink            request,
  tcw_out_if.source         result,
  tcw_cfg_if.sink           cfg
);
  import tcw_pkg::*;

  logic [CHAR_W-1:0]    attribute;
  logic [ROW_W-1:0]     cur_row;
  logic [COL_W-1:0]     cur_col;
  logic [CHAR_W-1:0]    item_char;
  logic [CHAR_W-1:0]    item_row;
  logic [CHAR_W-1:0]    item_col;
  logic                 neg;
  logic [NUM_W-1:0]     work;
  logic [STACK_W-1:0]   stack;
  logic [CNT_W-1:0]     cnt;
  logic                 out_valid;
  logic                 out_we;
  logic [ADDR_W-1:0]    out_addr;
  logic [DATA_W-1:0]    out_data;
  logic [ADDR_W-1:0]    out_pos;
  logic                 out_last;

  logic [2*NUM_W-1:0]   prod;
  logic [NUM_W-1:0]     quot;
  logic [DIGIT_W-1:0]   quot_x10;
  logic [DIGIT_W-1:0]   digit;
  logic [CHAR_W-1:0]    code;
  logic                 newline;
  logic                 writes;
  logic [ROW_W-1:0]     row_inc;
  logic [ROW_W-1:0]     row_next;
  logic [COL_W-1:0]     col_next;
  logic [NUM_W-1:0]     num_bits;

  always_comb begin
    prod     = {{NUM_W{1'b0}}, work} * {{NUM_W{1'b0}}, RECIP_TEN};
    quot     = NUM_W'(prod >> RECIP_SHIFT);
    quot_x10 = DIGIT_W'(quot[DIGIT_W-1:0] << 3) + DIGIT_W'(quot[DIGIT_W-1:0] << 1);
    digit    = work[DIGIT_W-1:0] - quot_x10;

    case (ctrl.cw.emit)
      EM_CHAR:  code = item_char;
      EM_MINUS: code = CHAR_MINUS;
      EM_DIGIT: code = CHAR_ZERO + CHAR_W'(stack[DIGIT_W-1:0]);
      EM_HEX:   code = nibble_ascii(work[NUM_W-1 -: DIGIT_W]);
      EM_ZERO:  code = CHAR_ZERO;
      EM_X:     code = CHAR_X;
      default:  code = '0;
    endcase
    newline = (code == NEWLINE_CODE);
    writes  = (ctrl.cw.emit != EM_MOVE) && !newline;

    row_inc = (cur_row == ROW_W'(ROWS - 1)) ? '0 : cur_row + ROW_W'(1);
    if (ctrl.cw.emit == EM_MOVE) begin
      row_next = (item_row >= CHAR_W'(ROWS)) ? ROW_W'(ROWS - 1) : ROW_W'(item_row);
      col_next = (item_col >= CHAR_W'(COLUMNS)) ? COL_W'(COLUMNS - 1) : COL_W'(item_col);
    end else if (newline) begin
      row_next = row_inc;
      col_next = '0;
    end else if (cur_col == COL_W'(COLUMNS - 1)) begin
      row_next = row_inc;
      col_next = '0;
    end else begin
      row_next = cur_row;
      col_next = cur_col + COL_W'(1);
    end

    num_bits = NUM_W'(request.number);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      attribute <= ATTR_RESET;
      cur_row   <= '0;
      cur_col   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        attribute <= cfg.data;
      end
      if (ctrl.emit) begin
        cur_row   <= row_next;
        cur_col   <= col_next;
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      item_char <= request.char_code;
      item_row  <= request.row;
      item_col  <= request.column;
      neg       <= num_bits[NUM_W-1];
      cnt       <= '0;
      if ((op_t'(request.operation) == OP_DEC) && num_bits[NUM_W-1]) begin
        work <= NUM_W'(0) - num_bits;
      end else begin
        work <= num_bits;
      end
    end else if (ctrl.fire) begin
      case (ctrl.cw.work)
        WK_DIV: begin
          work  <= quot;
          stack <= {stack[STACK_W-DIGIT_W-1:0], digit};
        end
        WK_SHIFT: work <= work << DIGIT_W;
        default: ;
      endcase
      if (ctrl.cw.emit == EM_DIGIT) begin
        stack <= stack >> DIGIT_W;
      end
      case (ctrl.cw.cnt_op)
        CN_INC:  cnt <= cnt + CNT_W'(1);
        CN_DEC:  cnt <= cnt - CNT_W'(1);
        default: ;
      endcase
    end
    if (ctrl.emit) begin
      out_we   <= writes;
      out_addr <= writes ? cell_pos(cur_row, cur_col) : '0;
      out_data <= writes ? {attribute, code} : '0;
      out_pos  <= cell_pos(row_next, col_next);
      out_last <= ctrl.last;
    end
  end

  assign cfg.ready              = 1'b1;
  assign result.valid           = out_valid;
  assign result.write_enable    = out_we;
  assign result.cell_address    = out_addr;
  assign result.cell_data       = out_data;
  assign result.cursor_position = out_pos;
  assign result.last            = out_last;

  assign status.neg          = neg;
  assign status.q_nonzero    = (quot != '0);
  assign status.cnt_one      = (cnt == CNT_W'(1));
  assign status.cnt_last_hex = (cnt == CNT_W'(HEX_DIGITS - 1));
  assign status.out_free     = !out_valid || result.ready;

endmodule
